FILE: hdl/acmas_pkg.sv
package acmas_pkg;

  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 12;
  localparam int SCALED_W   = 19;
  localparam int CAL_W      = 19;
  localparam int OFFSET_W   = 12;
  localparam int COEF_W     = 7;
  localparam int NUM_CAL    = 5;

  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_LSB = 2;
  localparam int REG_IDX_W  = PADDR_W - REG_IDX_LSB;

  localparam int FULL_SCALE_MV = 3300;
  localparam int FS_W          = 12;
  localparam int ADC_MAX       = 4095;

  // Divider: quotient bits per cycle and cycles per item
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = SAMPLE_W / DIV_STEPS;
  localparam int DIVCNT_W   = 2;

  // Scaling datapath widths
  localparam int PROD1_W = OFFSET_W + COEF_W;
  localparam int PROD2_W = PROD1_W + FS_W;
  localparam int Q0_W    = PROD2_W - SAMPLE_W;
  localparam int Y_W     = Q0_W + 1;
  localparam int Q1_W    = Y_W - SAMPLE_W;
  localparam int Z_W     = SAMPLE_W + 1;

  typedef logic [CAL_W-1:0] cal_t;

  localparam cal_t CAL_RESET [NUM_CAL] = '{
    19'd41030, 19'd45131, 19'd45131, 19'd4096, 19'd41030
  };

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CTRL  = 8'b0000_0010,
    S_RING  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_SCALE = 8'b0010_0000,
    S_FOLD  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

endpackage

FILE: hdl/adc_channel_moving_average_scaler.sv
// Channel   Handshake                  Payload
// --------  -------------------------  ------------------------------------
// in        in_valid / in_stall        channel, sample
// out       out_valid / out_stall      channel_out, filtered, scaled
// cfg       psel/penable/pwrite/pready paddr, pwdata, prdata (cal_ch0..4)
//
// An item passes through two dependent memory reads (channel state at
// acceptance, then the ring slot in S_CTRL), a write-back in S_RING, the
// 4-bit-per-cycle divider in S_DIV, and scaling and output load in S_MUL,
// S_SCALE, S_FOLD and S_EMIT before the next item is accepted.
// An item with a channel of CHANNELS or more is dropped at acceptance.
// Reset clears the channel state through per-channel valid bits; the sample
// ring needs no clearing: an old slot value is used only once the ring is full.
// A stalled result waits in the output register; the next item is still taken.
module adc_channel_moving_average_scaler #(
  parameter int CHANNELS = 5,
  parameter int WINDOW   = 16
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [acmas_pkg::PADDR_W-1:0]       paddr,
  input  logic [acmas_pkg::PDATA_W-1:0]       pwdata,
  output logic [acmas_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [acmas_pkg::CH_W-1:0]          channel,
  input  logic [acmas_pkg::SAMPLE_W-1:0]      sample,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [acmas_pkg::CH_W-1:0]          channel_out,
  output logic [acmas_pkg::SAMPLE_W-1:0]      filtered,
  output logic [acmas_pkg::SCALED_W-1:0]      scaled
);

  localparam int CIDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int SUM_W      = $clog2(WINDOW * acmas_pkg::ADC_MAX + 1);
  localparam int RING_DEPTH = CHANNELS * (2 ** SLOT_W);
  localparam int RING_AW    = CIDX_W + SLOT_W;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] fill;
    logic [SLOT_W-1:0] slot;
  } ctrl_t;

  acmas_pkg::state_t state;

  // Configuration registers
  acmas_pkg::cal_t                    cal_reg [acmas_pkg::NUM_CAL];
  logic [acmas_pkg::REG_IDX_W-1:0]    cfg_idx;
  logic                               cfg_we;

  // Current item
  logic [acmas_pkg::CH_W-1:0]         item_ch;
  logic [acmas_pkg::SAMPLE_W-1:0]     item_sample;
  logic [CIDX_W-1:0]                  ch_idx;
  logic                               in_fire;
  logic                               in_ok;

  // Channel state memory with valid bits
  ctrl_t                              ctrl_mem [CHANNELS];
  logic [CHANNELS-1:0]                ctrl_vld;
  ctrl_t                              ctrl_q;
  logic                               ctrl_q_vld;
  ctrl_t                              ctrl_cur;
  ctrl_t                              ctrl_upd;
  logic                               ring_full;

  // Sample ring memory
  logic [acmas_pkg::SAMPLE_W-1:0]     ring [RING_DEPTH];
  logic [acmas_pkg::SAMPLE_W-1:0]     ring_q;
  logic [RING_AW-1:0]                 ring_addr;

  // Divider
  logic [FILL_W-1:0]                  div_rem;
  logic [FILL_W-1:0]                  div_den;
  logic [acmas_pkg::SAMPLE_W-1:0]     div_num;
  logic [acmas_pkg::DIVCNT_W-1:0]     div_cnt;
  logic [FILL_W-1:0]                  div_rem_next;
  logic [acmas_pkg::SAMPLE_W-1:0]     div_num_next;

  // Scaling
  acmas_pkg::cal_t                    cal_sel;
  logic [acmas_pkg::OFFSET_W-1:0]     cal_offset;
  logic [acmas_pkg::COEF_W-1:0]       cal_coef;
  logic [acmas_pkg::OFFSET_W-1:0]     diff;
  logic [acmas_pkg::PROD1_W-1:0]      prod1;
  logic [acmas_pkg::PROD2_W-1:0]      prod2;
  logic [acmas_pkg::Q0_W-1:0]         fold_q0;
  logic [acmas_pkg::Y_W-1:0]          fold_y;
  logic [acmas_pkg::Q1_W-1:0]         fold_q1;
  logic [acmas_pkg::Z_W-1:0]          fold_z;
  logic [acmas_pkg::SCALED_W-1:0]     quot;
  logic                               out_load;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[acmas_pkg::PADDR_W-1:acmas_pkg::REG_IDX_LSB];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < acmas_pkg::NUM_CAL; i++) begin
        cal_reg[i] <= acmas_pkg::CAL_RESET[i];
      end
    end else if (cfg_we && (cfg_idx < acmas_pkg::REG_IDX_W'(acmas_pkg::NUM_CAL))) begin
      cal_reg[cfg_idx] <= pwdata[acmas_pkg::CAL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx < acmas_pkg::REG_IDX_W'(acmas_pkg::NUM_CAL)) begin
      prdata = acmas_pkg::PDATA_W'(cal_reg[cfg_idx]);
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  assign in_stall = (state != acmas_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign in_ok    = (channel < acmas_pkg::CH_W'(CHANNELS));
  assign ch_idx   = item_ch[CIDX_W-1:0];

  // ---------------------------------------------------------------------
  // Channel state update
  // ---------------------------------------------------------------------
  assign ctrl_cur  = ctrl_q_vld ? ctrl_q : '0;
  assign ring_full = (ctrl_cur.fill == FILL_W'(WINDOW));
  assign ring_addr = {ch_idx, ctrl_cur.slot};

  always_comb begin
    ctrl_upd = ctrl_cur;
    if (ring_full) begin
      // drop the oldest sample before the new one enters
      ctrl_upd.sum = ctrl_cur.sum - SUM_W'(ring_q) + SUM_W'(item_sample);
    end else begin
      ctrl_upd.sum  = ctrl_cur.sum + SUM_W'(item_sample);
      ctrl_upd.fill = ctrl_cur.fill + 1'b1;
    end
    if (ctrl_cur.slot == SLOT_W'(WINDOW - 1)) begin
      ctrl_upd.slot = '0;
    end else begin
      ctrl_upd.slot = ctrl_cur.slot + 1'b1;
    end
  end

  // Channel state memory: read at acceptance, written back in S_RING
  always_ff @(posedge clk) begin
    if (in_fire && in_ok) begin
      ctrl_q <= ctrl_mem[channel[CIDX_W-1:0]];
    end
    if (state == acmas_pkg::S_RING) begin
      ctrl_mem[ch_idx] <= ctrl_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_vld   <= '0;
      ctrl_q_vld <= 1'b0;
    end else begin
      if (in_fire && in_ok) begin
        ctrl_q_vld <= ctrl_vld[channel[CIDX_W-1:0]];
      end
      if (state == acmas_pkg::S_RING) begin
        ctrl_vld[ch_idx] <= 1'b1;
      end
    end
  end

  // Sample ring: read the slot in S_CTRL, overwrite it in S_RING
  always_ff @(posedge clk) begin
    if (state == acmas_pkg::S_CTRL) begin
      ring_q <= ring[ring_addr];
    end
    if (state == acmas_pkg::S_RING) begin
      ring[ring_addr] <= item_sample;
    end
  end

  // ---------------------------------------------------------------------
  // Restoring divider, DIV_STEPS quotient bits per cycle
  // ---------------------------------------------------------------------
  always_comb begin
    logic [FILL_W-1:0]              rem_v;
    logic [acmas_pkg::SAMPLE_W-1:0] num_v;
    logic [FILL_W:0]                trial;
    rem_v = div_rem;
    num_v = div_num;
    for (int i = 0; i < acmas_pkg::DIV_STEPS; i++) begin
      trial = {rem_v, num_v[acmas_pkg::SAMPLE_W-1]};
      if (trial >= {1'b0, div_den}) begin
        rem_v = FILL_W'(trial - {1'b0, div_den});
        num_v = {num_v[acmas_pkg::SAMPLE_W-2:0], 1'b1};
      end else begin
        rem_v = trial[FILL_W-1:0];
        num_v = {num_v[acmas_pkg::SAMPLE_W-2:0], 1'b0};
      end
    end
    div_rem_next = rem_v;
    div_num_next = num_v;
  end

  // ---------------------------------------------------------------------
  // Scaling: x = diff * coef * 3300, then x / 4095 by folding 4096 = 4095 + 1
  // ---------------------------------------------------------------------
  assign cal_sel    = cal_reg[item_ch];
  assign cal_offset = cal_sel[acmas_pkg::OFFSET_W-1:0];
  assign cal_coef   = cal_sel[acmas_pkg::CAL_W-1:acmas_pkg::OFFSET_W];
  assign diff       = (div_num > cal_offset) ? (div_num - cal_offset) : '0;

  assign fold_q1 = fold_y[acmas_pkg::Y_W-1:acmas_pkg::SAMPLE_W];
  assign fold_z  = acmas_pkg::Z_W'(fold_q1)
                 + acmas_pkg::Z_W'(fold_y[acmas_pkg::SAMPLE_W-1:0]);
  assign quot    = acmas_pkg::SCALED_W'(fold_q0)
                 + acmas_pkg::SCALED_W'(fold_q1)
                 + acmas_pkg::SCALED_W'(fold_z >= acmas_pkg::Z_W'(acmas_pkg::ADC_MAX));

  assign out_load = (state == acmas_pkg::S_EMIT) && !(out_valid && out_stall);

  // ---------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= acmas_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        acmas_pkg::S_IDLE: begin
          if (in_fire && in_ok) begin
            item_ch     <= channel;
            item_sample <= sample;
            state       <= acmas_pkg::S_CTRL;
          end
        end
        acmas_pkg::S_CTRL: begin
          state <= acmas_pkg::S_RING;
        end
        acmas_pkg::S_RING: begin
          // sum < fill * 4096, so the upper part already sits below the divisor
          div_rem <= FILL_W'(ctrl_upd.sum >> acmas_pkg::SAMPLE_W);
          div_num <= ctrl_upd.sum[acmas_pkg::SAMPLE_W-1:0];
          div_den <= ctrl_upd.fill;
          div_cnt <= '0;
          state   <= acmas_pkg::S_DIV;
        end
        acmas_pkg::S_DIV: begin
          div_rem <= div_rem_next;
          div_num <= div_num_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == acmas_pkg::DIVCNT_W'(acmas_pkg::DIV_CYCLES - 1)) begin
            state <= acmas_pkg::S_MUL;
          end
        end
        acmas_pkg::S_MUL: begin
          prod1 <= acmas_pkg::PROD1_W'(diff) * acmas_pkg::PROD1_W'(cal_coef);
          state <= acmas_pkg::S_SCALE;
        end
        acmas_pkg::S_SCALE: begin
          prod2 <= acmas_pkg::PROD2_W'(prod1) * acmas_pkg::PROD2_W'(acmas_pkg::FULL_SCALE_MV);
          state <= acmas_pkg::S_FOLD;
        end
        acmas_pkg::S_FOLD: begin
          fold_q0 <= prod2[acmas_pkg::PROD2_W-1:acmas_pkg::SAMPLE_W];
          fold_y  <= acmas_pkg::Y_W'(prod2[acmas_pkg::PROD2_W-1:acmas_pkg::SAMPLE_W])
                   + acmas_pkg::Y_W'(prod2[acmas_pkg::SAMPLE_W-1:0]);
          state   <= acmas_pkg::S_EMIT;
        end
        acmas_pkg::S_EMIT: begin
          // hold until the output register is free
          if (out_load) begin
            out_valid   <= 1'b1;
            channel_out <= item_ch;
            filtered    <= div_num;
            scaled      <= quot;
            state       <= acmas_pkg::S_IDLE;
          end
        end
        default: begin
          state <= acmas_pkg::S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ok) |=> (state == acmas_pkg::S_CTRL))
    else $error("accepted item did not start the channel state read");

  a_ctrl_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == acmas_pkg::S_RING) |->
      (ctrl_upd.fill != '0) && (ctrl_upd.fill <= FILL_W'(WINDOW)) &&
      ({1'b0, ctrl_upd.slot} < (SLOT_W + 1)'(WINDOW)))
    else $error("channel state written back out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == acmas_pkg::S_DIV) |-> (div_rem < div_den))
    else $error("divider remainder not below divisor");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == acmas_pkg::S_IDLE))
    else $error("finished item not loaded into the output register");

endmodule

FILE: sim/testbench.sv
module testbench;

  localparam int CH_W     = acmas_pkg::CH_W;
  localparam int SAMPLE_W = acmas_pkg::SAMPLE_W;
  localparam int SCALED_W = acmas_pkg::SCALED_W;
  localparam int CAL_W    = acmas_pkg::CAL_W;
  localparam int OFFSET_W = acmas_pkg::OFFSET_W;
  localparam int COEF_W   = acmas_pkg::COEF_W;
  localparam int NUM_CAL  = acmas_pkg::NUM_CAL;
  localparam int PADDR_W  = acmas_pkg::PADDR_W;
  localparam int PDATA_W  = acmas_pkg::PDATA_W;
  typedef acmas_pkg::cal_t cal_t;

  localparam int NCH          = 5;
  localparam int WIN          = 16;
  localparam int LIMIT        = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 215;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] avg;
    logic [SCALED_W-1:0] scaled;
  } reading_t;

  class avg_scoreboard;
    cal_t                cal [NUM_CAL];
    logic [SAMPLE_W-1:0] ring [NCH][WIN];
    logic [19:0]         sum [NCH];
    int unsigned         fill [NCH];
    int unsigned         slot [NCH];
    reading_t            expected_q [$];
    int                  errors;

    function new();
      foreach (cal[i]) cal[i] = acmas_pkg::CAL_RESET[i];
      foreach (sum[i]) begin
        sum[i]  = '0;
        fill[i] = 0;
        slot[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_cal(int idx, cal_t value);
      cal[idx] = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the channel's window and queue the reading it should produce
    function void note_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      reading_t            r;
      logic [SAMPLE_W-1:0] avg;
      logic [OFFSET_W-1:0] off;
      logic [COEF_W-1:0]   coef;
      logic [63:0]         prod;
      if (ch >= NCH) return;
      if (fill[ch] >= WIN) sum[ch] -= ring[ch][slot[ch]];
      else fill[ch]++;
      ring[ch][slot[ch]] = smp;
      sum[ch] += smp;
      slot[ch] = (slot[ch] + 1) % WIN;
      avg  = SAMPLE_W'(sum[ch] / fill[ch]);
      off  = cal[ch][OFFSET_W-1:0];
      coef = cal[ch][CAL_W-1:OFFSET_W];
      prod = (avg > off)
           ? 64'(avg - off) * 64'(acmas_pkg::FULL_SCALE_MV) * 64'(coef)
           : 64'd0;
      r.ch     = ch;
      r.avg    = avg;
      r.scaled = SCALED_W'(prod / 64'(acmas_pkg::ADC_MAX));
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    task check_reading(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] avg,
                       logic [SCALED_W-1:0] scaled);
      reading_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result ch %0d filtered %0d scaled %0d",
                         ch, avg, scaled));
        return;
      end
      want = expected_q.pop_front();
      if (ch !== want.ch)
        report($sformatf("channel_out got %0d want %0d", ch, want.ch));
      if (avg !== want.avg)
        report($sformatf("ch %0d filtered got %0d want %0d", want.ch, avg, want.avg));
      if (scaled !== want.scaled)
        report($sformatf("ch %0d scaled got %0d want %0d", want.ch, scaled, want.scaled));
    endtask
  endclass

  logic                clk;
  logic                rst      = 1'b1;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [PADDR_W-1:0]  paddr    = '0;
  logic [PDATA_W-1:0]  pwdata   = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CH_W-1:0]     channel  = '0;
  logic [SAMPLE_W-1:0] sample   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CH_W-1:0]     channel_out;
  logic [SAMPLE_W-1:0] filtered;
  logic [SCALED_W-1:0] scaled;

  avg_scoreboard sb;
  int            in_idle_pct  = 0;
  int            out_idle_pct = 0;
  int            out_count    = 0;
  int            quiet_cycles = 0;
  int            hold_left    = 0;
  bit            hold_armed   = 1'b1;

  adc_channel_moving_average_scaler dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .channel(channel), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .channel_out(channel_out),
    .filtered(filtered), .scaled(scaled)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: one long hold-off early on so the block backs up, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_armed && out_count >= 80) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_sample(channel, sample);
      if (out_valid && !out_stall) begin
        out_count++;
        sb.check_reading(channel_out, filtered, scaled);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one item, idling first at the current rate; return once it is taken
  task automatic send_item(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel  <= ch;
    sample   <= smp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_cal(input int p);
    cal_t v;
    for (int i = 0; i < NUM_CAL; i++) begin
      case (p)
        1:       v = {7'd127, 12'd0};
        3:       v = (i % 2) ? {7'd0, 12'd0} : {7'd0, 12'd4095};
        4:       v = (i < 2) ? '1 : {7'd127, 12'($urandom_range(200))};
        default: v = CAL_W'($urandom_range(524287));
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'(i << acmas_pkg::REG_IDX_LSB);
      pwdata  <= PDATA_W'(v);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_cal(i, v);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int                  counted;
    int                  v;
    int                  k;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] level [NCH];
    sb = new();
    foreach (level[i]) level[i] = SAMPLE_W'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes per channel, dropped channels, and values around the reset offsets
    for (int c = 0; c < NCH; c++) begin
      send_item(CH_W'(c), 12'hFFF);
      send_item(CH_W'(c), 12'h000);
    end
    send_item(3'd5, 12'hAAA);
    send_item(3'd6, 12'h555);
    send_item(3'd7, 12'hFFF);
    send_item(3'd3, 12'h001);
    send_item(3'd0, 12'd70);
    send_item(3'd1, 12'h555);
    send_item(3'd2, 12'hAAA);
    send_item(3'd4, 12'd0);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        load_cal(p);
      end
      case (p % 4)
        0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
        1: begin in_idle_pct = 83; out_idle_pct = 0;  end
        2: begin in_idle_pct = 0;  out_idle_pct = 83; end
        default: begin in_idle_pct = 36; out_idle_pct = 36; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(99) < 4) begin
          send_item(CH_W'($urandom_range(7, NCH)), SAMPLE_W'($urandom));
        end else begin
          ch = CH_W'($urandom_range(NCH - 1));
          k  = $urandom_range(9);
          if (k <= 2) begin
            v = $urandom_range(4095);
          end else if (k == 3) begin
            v = $urandom_range(1) ? 4095 : 0;
          end else if (k <= 5) begin
            // hover around the offset so the clamp flips both ways
            v = int'(sb.cal[ch][OFFSET_W-1:0]) + int'($urandom_range(16)) - 8;
          end else begin
            if ($urandom_range(31) == 0) level[ch] = SAMPLE_W'($urandom);
            v = int'(level[ch]) + int'($urandom_range(32)) - 16;
          end
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          send_item(ch, SAMPLE_W'(v));
          counted++;
        end
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
